>>> hw/rtl/rpn_pkg.sv
package rpn_pkg;

  // Token codes carried on the action field.
  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_ADD    = 3'd1;
  localparam logic [2:0] ACT_SUB    = 3'd2;
  localparam logic [2:0] ACT_MUL    = 3'd3;
  localparam logic [2:0] ACT_DIV    = 3'd4;
  localparam logic [2:0] ACT_FINISH = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNDER   = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  localparam int unsigned DataW = 32;
  localparam int unsigned DivCntW = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DIV_END,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/rpn_stack_evaluator.sv
// Reverse Polish integer evaluator on a bounded operand stack. Each input transfer carries one
// token: push a signed 32-bit operand, add, subtract, multiply, divide (truncating toward zero)
// or finish, which returns the top entry and pops it. Every token gives exactly one output
// transfer with the new top (or the popped answer), the depth after the step and a status:
// underflow, overflow and divide by zero leave the stack untouched. The top entry lives in a
// register and the entries below it in a single-port-read, single-port-write synchronous RAM of
// STACK_DEPTH words, so no clearing pass is needed after reset. One token is processed at a
// time. A push, an unused code or any token that fails its check passes from the idle state
// to the done state and then into the output register; add, subtract, multiply and a finish
// with two or more entries first pass through a read state that waits for the RAM read of
// the entry below the top; a divide then runs the restoring divider, which retires one
// quotient bit per cycle, and an end state. A new token is taken in the cycle after the previous
// result has moved into the output register, even if that result has not yet been taken
// downstream; while the output register is still full, the finished result waits and the
// input stays closed.
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 1024,
  localparam int unsigned PtrW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               action,
  input  logic signed [31:0]       operand,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       top_data,
  output logic [PtrW-1:0]          stack_depth,
  output logic [1:0]               status
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [PtrW-1:0] SpFull = PtrW'(STACK_DEPTH);
  localparam logic [PtrW-1:0] SpOne  = PtrW'(1);
  localparam logic [PtrW-1:0] SpTwo  = PtrW'(2);

  rpn_pkg::state_t state, state_next;

  // Stack state: the top entry is held in a register, the rest in RAM.
  logic [PtrW-1:0]             sp;
  logic [rpn_pkg::DataW-1:0]   top;
  logic [rpn_pkg::DataW-1:0]   stack_mem [STACK_DEPTH];
  logic [rpn_pkg::DataW-1:0]   rd_data;

  // Token being worked on and its pending result.
  logic [2:0]                  act;
  logic [rpn_pkg::DataW-1:0]   res_top;
  logic [1:0]                  res_status;

  // Restoring divider on magnitudes.
  logic [rpn_pkg::DataW-1:0]   rem;
  logic [rpn_pkg::DataW-1:0]   quo;
  logic [rpn_pkg::DataW-1:0]   dvs;
  logic                        neg;
  logic [rpn_pkg::DivCntW-1:0] div_cnt;

  // Control from the output block.
  logic accept;
  logic mem_we;
  logic mem_re;
  logic out_load;

  // Decode and arithmetic.
  logic                        is_op;
  logic                        sp_ge2;
  logic                        div_by_zero;
  logic [1:0]                  tok_status;
  logic [rpn_pkg::DataW-1:0]   top_or_zero;
  logic [rpn_pkg::DataW-1:0]   alu_r;
  logic [rpn_pkg::DataW-1:0]   abs_a;
  logic [rpn_pkg::DataW-1:0]   abs_b;
  logic [rpn_pkg::DataW:0]     rem_sh;
  logic                        rem_ge;
  logic [rpn_pkg::DataW-1:0]   rem_step;
  logic [rpn_pkg::DataW-1:0]   quo_fixed;
  logic [AddrW-1:0]            wr_addr;
  logic [AddrW-1:0]            rd_addr;

  always_comb begin
    is_op       = action inside {rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB,
                                 rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV};
    sp_ge2      = (sp >= SpTwo);
    div_by_zero = (action == rpn_pkg::ACT_DIV) && (top == '0);
    top_or_zero = (sp == '0) ? '0 : top;
    wr_addr     = AddrW'(sp - SpOne);
    rd_addr     = AddrW'(sp - SpTwo);
  end

  // Status of the token on the input, judged against the stack as it stands. Underflow is
  // checked before divide by zero.
  always_comb begin
    tok_status = rpn_pkg::ST_OK;
    if (action == rpn_pkg::ACT_PUSH) begin
      if (sp == SpFull) begin
        tok_status = rpn_pkg::ST_OVER;
      end
    end else if (is_op) begin
      if (!sp_ge2) begin
        tok_status = rpn_pkg::ST_UNDER;
      end else if (div_by_zero) begin
        tok_status = rpn_pkg::ST_DIVZERO;
      end
    end else if ((action == rpn_pkg::ACT_FINISH) && (sp == '0)) begin
      tok_status = rpn_pkg::ST_UNDER;
    end
  end

  // Result of add, subtract or multiply once the second operand has been read.
  always_comb begin
    case (act)
      rpn_pkg::ACT_ADD: alu_r = rd_data + top;
      rpn_pkg::ACT_SUB: alu_r = rd_data - top;
      rpn_pkg::ACT_MUL: alu_r = rd_data * top;
      default:          alu_r = rd_data;
    endcase
  end

  always_comb begin
    abs_a     = rd_data[rpn_pkg::DataW-1] ? (-rd_data) : rd_data;
    abs_b     = top[rpn_pkg::DataW-1] ? (-top) : top;
    rem_sh    = {rem, quo[rpn_pkg::DataW-1]};
    rem_ge    = (rem_sh >= {1'b0, dvs});
    rem_step  = rem_ge ? rpn_pkg::DataW'(rem_sh - {1'b0, dvs}) : rem_sh[rpn_pkg::DataW-1:0];
    quo_fixed = neg ? (-quo) : quo;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rpn_pkg::S_IDLE: begin
        if (in_valid) begin
          if (is_op && sp_ge2 && !div_by_zero) begin
            state_next = rpn_pkg::S_READ;
          end else if ((action == rpn_pkg::ACT_FINISH) && sp_ge2) begin
            state_next = rpn_pkg::S_READ;
          end else begin
            state_next = rpn_pkg::S_DONE;
          end
        end
      end
      rpn_pkg::S_READ: begin
        state_next = (act == rpn_pkg::ACT_DIV) ? rpn_pkg::S_DIV : rpn_pkg::S_DONE;
      end
      rpn_pkg::S_DIV: begin
        if (div_cnt == '1) begin
          state_next = rpn_pkg::S_DIV_END;
        end
      end
      rpn_pkg::S_DIV_END: begin
        state_next = rpn_pkg::S_DONE;
      end
      rpn_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = rpn_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rpn_pkg::S_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready = (state == rpn_pkg::S_IDLE);
    accept   = in_ready && in_valid;
    mem_we   = accept && (action == rpn_pkg::ACT_PUSH) && (sp != '0) && (sp != SpFull);
    mem_re   = accept && sp_ge2 &&
               ((is_op && !div_by_zero) || (action == rpn_pkg::ACT_FINISH));
    out_load = (state == rpn_pkg::S_DONE) && (!out_valid || out_ready);
  end

  // Stack RAM: the write moves the old top down on a push, the read fetches the entry below it.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= top;
    end
    if (mem_re) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpn_pkg::S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      state <= state_next;

      // A new result may replace the one leaving in the same cycle.
      if (out_load) begin
        out_valid   <= 1'b1;
        top_data    <= res_top;
        stack_depth <= sp;
        status      <= res_status;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        rpn_pkg::S_IDLE: begin
          if (accept) begin
            act        <= action;
            res_status <= tok_status;
            if ((action == rpn_pkg::ACT_PUSH) && (tok_status == rpn_pkg::ST_OK)) begin
              top     <= operand;
              res_top <= operand;
              sp      <= sp + SpOne;
            end else begin
              res_top <= top_or_zero;
              if ((action == rpn_pkg::ACT_FINISH) && (tok_status == rpn_pkg::ST_OK)) begin
                sp <= sp - SpOne;
              end
            end
          end
        end
        rpn_pkg::S_READ: begin
          if (act == rpn_pkg::ACT_FINISH) begin
            // The popped answer is already in res_top; refill the top register.
            top <= rd_data;
          end else if (act == rpn_pkg::ACT_DIV) begin
            rem     <= '0;
            quo     <= abs_a;
            dvs     <= abs_b;
            neg     <= rd_data[rpn_pkg::DataW-1] ^ top[rpn_pkg::DataW-1];
            div_cnt <= '0;
          end else begin
            top     <= alu_r;
            res_top <= alu_r;
            sp      <= sp - SpOne;
          end
        end
        rpn_pkg::S_DIV: begin
          rem     <= rem_step;
          quo     <= {quo[rpn_pkg::DataW-2:0], rem_ge};
          div_cnt <= div_cnt + rpn_pkg::DivCntW'(1);
        end
        rpn_pkg::S_DIV_END: begin
          top     <= quo_fixed;
          res_top <= quo_fixed;
          sp      <= sp - SpOne;
        end
        default: begin
        end
      endcase
    end
  end

  // The stack pointer never passes the capacity.
  a_sp_bound: assert property (@(posedge clk) disable iff (rst) sp <= SpFull)
    else $error("stack pointer beyond capacity");

  // While idle and not taking a token, the depth cannot move.
  a_sp_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == rpn_pkg::S_IDLE) && !accept |=> $stable(sp))
    else $error("stack pointer changed without a token");

  // The divider count is only live while iterating.
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state != rpn_pkg::S_DIV) |-> (div_cnt == '0))
    else $error("divider count left non-zero");

  // A divide by zero can only be reported with two operands present.
  a_divz_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == rpn_pkg::ST_DIVZERO) |-> (stack_depth >= SpTwo))
    else $error("divide by zero reported on a short stack");

  // The read state is only entered after a RAM read has been issued.
  a_read_path: assert property (@(posedge clk) disable iff (rst)
    (state == rpn_pkg::S_READ) |-> $past(mem_re))
    else $error("read state entered without a RAM read");

endmodule

>>> sim/rpn_stack_evaluator_test.sv
module rpn_stack_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Stack size that the block is built with for this run: the default size.
  localparam int STACK_ENTRIES = 1024;
  localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);

  // The two action codes that the block defines no meaning for. Both must be ignored.
  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  // Extreme operand values.
  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0]        top;
    logic [DEPTH_W-1:0] depth;
    logic [1:0]         status;
  } token_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               action = rpn_pkg::ACT_PUSH;
  logic [31:0]              operand = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [31:0]       top_data;
  logic [DEPTH_W-1:0]       stack_depth;
  logic [1:0]               status;

  // Our own copy of the operand stack, kept in step with every accepted transfer.
  logic [31:0]   operand_mem [STACK_ENTRIES];
  int            stack_count = 0;

  // Results that the block still owes us, oldest first.
  token_result_t pending_results [$];
  int            error_count = 0;

  // Idling controls: when a side is steady it never idles. The hold-off request is a number of
  // cycles during which the receiver refuses every result.
  bit            source_steady = 1'b0;
  bit            sink_steady = 1'b0;
  logic          sink_hold = 1'b0;
  int            hold_request = 0;

  rpn_stack_evaluator #(
    .STACK_DEPTH(STACK_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .operand(operand),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .top_data(top_data),
    .stack_depth(stack_depth),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // A hard ceiling on the run. Even the slowest legal run (every token a full division, every
  // result held back by the longest receiver stall) finishes far inside this.
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // Works out what one token does to the stack and which result it should produce. It is
  // called once per accepted transfer, so the stack copy moves exactly as the block's does.
  function automatic token_result_t evaluate_token(input logic [2:0] act,
                                                   input logic [31:0] val);
    token_result_t r;
    logic [31:0]   lhs;
    logic [31:0]   rhs;
    logic [31:0]   answer;
    longint        quot;
    bit            popped;
    r = '0;
    answer = '0;
    popped = 1'b0;
    r.status = rpn_pkg::ST_OK;
    case (act)
      rpn_pkg::ACT_PUSH: begin
        if (stack_count >= STACK_ENTRIES) begin
          r.status = rpn_pkg::ST_OVER;
        end else begin
          operand_mem[stack_count] = val;
          stack_count++;
        end
      end
      rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV: begin
        if (stack_count < 2) begin
          r.status = rpn_pkg::ST_UNDER;
        end else begin
          lhs = operand_mem[stack_count - 2];
          rhs = operand_mem[stack_count - 1];
          if (act == rpn_pkg::ACT_DIV && rhs == '0) begin
            r.status = rpn_pkg::ST_DIVZERO;
          end else begin
            case (act)
              rpn_pkg::ACT_ADD: answer = lhs + rhs;
              rpn_pkg::ACT_SUB: answer = lhs - rhs;
              rpn_pkg::ACT_MUL: answer = lhs * rhs;
              default: begin
                // Worked out in 64 bits so that the most negative value over minus one
                // yields +2^31, whose low half wraps back to the most negative value.
                quot = longint'($signed(lhs)) / longint'($signed(rhs));
                answer = quot[31:0];
              end
            endcase
            stack_count--;
            operand_mem[stack_count - 1] = answer;
          end
        end
      end
      rpn_pkg::ACT_FINISH: begin
        if (stack_count == 0) begin
          r.status = rpn_pkg::ST_UNDER;
        end else begin
          r.top = operand_mem[stack_count - 1];
          stack_count--;
          popped = 1'b1;
        end
      end
      default: begin
        // Unused codes leave everything alone.
      end
    endcase
    // A finish reports the entry it removed; every other token reports what is left on top.
    if (!popped) begin
      r.top = (stack_count == 0) ? '0 : operand_mem[stack_count - 1];
    end
    r.depth = DEPTH_W'(stack_count);
    return r;
  endfunction

  // Offers one token and returns once it has been transferred. Valid is left high on return,
  // so a token that follows at once keeps it high; anything that lets time pass afterwards
  // must lower it first.
  task automatic send_token(input logic [2:0] act, input logic [31:0] val);
    while (!source_steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    operand <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(evaluate_token(act, val));
  endtask

  // Lowers valid and waits until every outstanding result has been transferred.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Operands lean towards the awkward values: zero (to set up division by zero), minus one
  // and the most negative value (to meet the wrapping quotient), the most positive value
  // (to make addition wrap) and small numbers, so that quotients are not always zero.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return MINUS_ONE;
      2: return INT_MIN;
      3: return INT_MAX;
      4, 5: return 32'(int'($urandom_range(40)) - 20);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_operator();
    return rpn_pkg::ACT_ADD + 3'($urandom_range(3));
  endfunction

  // One token of a well-formed expression, chosen from the depth the stack has now. With the
  // given chance in a hundred the token is noise instead: any code at all, so operators on a
  // short stack, finishes on an empty one and the unused codes also turn up.
  task automatic send_random_token(input int depth_cap, input int noise_pct);
    logic [2:0] act;
    int         roll;
    roll = $urandom_range(99);
    if ($urandom_range(99) < noise_pct) begin
      act = 3'($urandom_range(7));
    end else if (stack_count < 2) begin
      act = (stack_count == 1 && roll < 20) ? rpn_pkg::ACT_FINISH : rpn_pkg::ACT_PUSH;
    end else if (stack_count > depth_cap) begin
      act = (roll < 85) ? pick_operator() : rpn_pkg::ACT_FINISH;
    end else begin
      act = (roll < 45) ? rpn_pkg::ACT_PUSH : (roll < 90) ? pick_operator() :
            rpn_pkg::ACT_FINISH;
    end
    send_token(act, (act == rpn_pkg::ACT_PUSH) ? pick_operand() : $urandom());
  endtask

  // The receiver: checks every result that is transferred against the oldest prediction,
  // then chooses whether to accept in the next cycle.
  always @(posedge clk) begin : result_check
    token_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no token outstanding: top %h depth %0d status %0d",
                                  top_data, stack_depth, status));
      end else begin
        want = pending_results.pop_front();
        if (top_data !== want.top) begin
          report_mismatch($sformatf("top_data %h, expected %h", top_data, want.top));
        end
        if (stack_depth !== want.depth) begin
          report_mismatch($sformatf("stack_depth %0d, expected %0d", stack_depth, want.depth));
        end
        if (status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        end
      end
    end
    out_ready <= !sink_hold && (sink_steady || $urandom_range(99) >= 30);
  end

  // Counts out a requested receiver hold-off in cycles of its own.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        sink_hold <= 1'b1;
        repeat (hold_request) @(posedge clk);
        sink_hold <= 1'b0;
        hold_request = 0;
      end
    end
  end

  // A short hand-written expression that meets each special case once: underflow on an empty
  // stack and on a single entry, both unused codes, addition and multiplication wrapping, the
  // most negative value divided by minus one, division by zero, truncation of negative
  // quotients towards zero and a finish on an empty stack.
  task automatic test_directed_corners();
    send_token(rpn_pkg::ACT_FINISH, $urandom());
    send_token(rpn_pkg::ACT_ADD, $urandom());
    send_token(rpn_pkg::ACT_PUSH, INT_MAX);
    send_token(rpn_pkg::ACT_SUB, $urandom());
    send_token(ACT_UNUSED_LO, $urandom());
    send_token(ACT_UNUSED_HI, $urandom());
    send_token(rpn_pkg::ACT_PUSH, 32'd1);
    send_token(rpn_pkg::ACT_ADD, $urandom());
    send_token(rpn_pkg::ACT_PUSH, MINUS_ONE);
    send_token(rpn_pkg::ACT_MUL, $urandom());
    send_token(rpn_pkg::ACT_PUSH, MINUS_ONE);
    send_token(rpn_pkg::ACT_DIV, $urandom());
    send_token(rpn_pkg::ACT_PUSH, '0);
    send_token(rpn_pkg::ACT_DIV, $urandom());
    send_token(rpn_pkg::ACT_PUSH, 32'd7);
    send_token(rpn_pkg::ACT_SUB, $urandom());
    send_token(rpn_pkg::ACT_PUSH, 32'd2);
    send_token(rpn_pkg::ACT_DIV, $urandom());
    send_token(rpn_pkg::ACT_DIV, $urandom());
    send_token(rpn_pkg::ACT_FINISH, $urandom());
    send_token(rpn_pkg::ACT_FINISH, $urandom());
  endtask

  task automatic test_random_expressions(input int count);
    repeat (count) send_random_token(8, 8);
  endtask

  // Neither side idles here, so tokens arrive as fast as the block will take them.
  task automatic test_back_to_back(input int count);
    source_steady = 1'b1;
    sink_steady = 1'b1;
    repeat (count) send_random_token(12, 3);
    source_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  // The receiver refuses results for a long stretch while the sender keeps offering tokens,
  // so the output register fills and the block must stall its input. Afterwards the sender
  // pauses until everything owed has come out.
  task automatic test_backpressure();
    hold_request = 300;
    repeat (40) send_random_token(8, 5);
    wait_drained();
  endtask

  // Builds the stack up to its full size, tries to push past it, and then works a stretch of
  // operators and finishes on the deep stack.
  task automatic test_fill_and_drain(input int drain_count);
    while (stack_count < STACK_ENTRIES) begin
      if ($urandom_range(99) < 95) begin
        send_token(rpn_pkg::ACT_PUSH, pick_operand());
      end else begin
        send_token(($urandom_range(4) == 0) ? rpn_pkg::ACT_FINISH : pick_operator(),
                   $urandom());
      end
    end
    repeat (4) send_token(rpn_pkg::ACT_PUSH, pick_operand());
    send_token(ACT_UNUSED_HI, $urandom());
    repeat (drain_count) begin
      if ($urandom_range(99) < 10) begin
        send_token(rpn_pkg::ACT_PUSH, pick_operand());
      end else begin
        send_token(($urandom_range(9) == 0) ? rpn_pkg::ACT_FINISH : pick_operator(),
                   $urandom());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_random_expressions(150);
    test_back_to_back(120);
    test_backpressure();
    test_fill_and_drain(180);
    wait_drained();
    // A division is the longest token the block has; allow well over that for a stray result.
    repeat (80) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
